FILE: rtl/lft_pkg.sv
// shared types, codes and character helpers for the formula tokenizer
package lft_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_EQ    = 3'd2,
        MODE_LT    = 3'd3,
        MODE_LTEQ  = 3'd4,
        MODE_ERR   = 3'd5
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_ID      = 4'd1,
        KIND_TRUE    = 4'd2,
        KIND_FALSE   = 4'd3,
        KIND_LPAREN  = 4'd4,
        KIND_RPAREN  = 4'd5,
        KIND_NOT     = 4'd6,
        KIND_AND     = 4'd7,
        KIND_OR      = 4'd8,
        KIND_IMPLIES = 4'd9,
        KIND_IFF     = 4'd10,
        KIND_ERROR   = 4'd11,
        KIND_CHAR    = 4'd12
    } token_kind_t;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;

    // keyword match progress, all ones once the word can no longer match
    localparam logic [2:0] NO_MATCH  = 3'd7;
    localparam logic [2:0] TRUE_LEN  = 3'd4;
    localparam logic [2:0] FALSE_LEN = 3'd5;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

    typedef struct packed {
        token_kind_t       kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } scan_out_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // "True"
    function automatic logic [2:0] adv_true(input logic [2:0] p, input logic [CHAR_W-1:0] c);
        logic [2:0] r;
        r = NO_MATCH;
        case (p)
            3'd0: if (c == 8'h54) r = 3'd1;
            3'd1: if (c == 8'h72) r = 3'd2;
            3'd2: if (c == 8'h75) r = 3'd3;
            3'd3: if (c == 8'h65) r = 3'd4;
            default: r = NO_MATCH;
        endcase
        return r;
    endfunction

    // "False"
    function automatic logic [2:0] adv_false(input logic [2:0] p, input logic [CHAR_W-1:0] c);
        logic [2:0] r;
        r = NO_MATCH;
        case (p)
            3'd0: if (c == 8'h46) r = 3'd1;
            3'd1: if (c == 8'h61) r = 3'd2;
            3'd2: if (c == 8'h6C) r = 3'd3;
            3'd3: if (c == 8'h73) r = 3'd4;
            3'd4: if (c == 8'h65) r = 3'd5;
            default: r = NO_MATCH;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/logic_formula_tokenizer_core.sv
// top level of the propositional formula tokenizer
// Takes one character per cycle on the s_ channel while s_tready is high (s_tlast
// marks end of input, the character is then ignored) and returns tokens on the m_
// channel, one per cycle while m_tready is high. A request is accepted every cycle
// as long as the output side keeps up; a request that yields two results (an
// identifier closed by a one-character symbol, or end of input right after an
// identifier) puts both into the queue at once, to be given out in turn.
// Results are written into a four-entry queue on acceptance and leave it in
// order; s_tready drops when fewer than two entries are free. Whitespace between
// tokens and characters absorbed by error or symbol states give no result.
module logic_formula_tokenizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] ident_char
    output logic [3:0] m_tuser,   // [3:0] token_kind
    output logic       m_tlast    // last_of_run
);
    import lft_pkg::*;

    scan_out_t scan_out;
    result_t   head;
    logic      take;
    logic      room;

    assign take     = s_tvalid && s_tready;
    assign s_tready = room;

    lft_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (take),
        .in_char  (s_tdata),
        .in_eoi   (s_tlast),
        .scan_out (scan_out)
    );

    lft_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_data (scan_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head.ch;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: rtl/lft_scan.sv
// scanner state and per-character token decision, up to two results per request
module lft_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_take,
    input  logic [lft_pkg::CHAR_W-1:0] in_char,
    input  logic                      in_eoi,
    output lft_pkg::scan_out_t        scan_out
);
    import lft_pkg::*;

    typedef struct packed {
        logic        emit;
        token_kind_t kind;
        logic [CHAR_W-1:0] ch;
        scan_mode_t  mode;
        logic [2:0]  tp;
        logic [2:0]  fp;
    } start_t;

    scan_mode_t mode_reg, mode_next;
    logic [2:0] tp_reg, tp_next;
    logic [2:0] fp_reg, fp_next;
    start_t     st;
    token_kind_t close_kind;
    scan_out_t  so;

    // handling of a character seen between tokens
    function automatic start_t start_char(input logic [CHAR_W-1:0] c);
        start_t s;
        s.emit = 1'b0;
        s.kind = KIND_END;
        s.ch   = '0;
        s.mode = MODE_IDLE;
        s.tp   = 3'd0;
        s.fp   = 3'd0;
        if (c == CH_SPACE || c == CH_LF || c == CH_TAB) begin
            s.emit = 1'b0;
        end else if (is_letter(c)) begin
            s.emit = 1'b1;
            s.kind = KIND_CHAR;
            s.ch   = c;
            s.mode = MODE_IDENT;
            s.tp   = adv_true(3'd0, c);
            s.fp   = adv_false(3'd0, c);
        end else begin
            case (c)
                CH_LPAR: begin
                    s.emit = 1'b1;
                    s.kind = KIND_LPAREN;
                end
                CH_RPAR: begin
                    s.emit = 1'b1;
                    s.kind = KIND_RPAREN;
                end
                CH_BANG: begin
                    s.emit = 1'b1;
                    s.kind = KIND_NOT;
                end
                CH_AMP: begin
                    s.emit = 1'b1;
                    s.kind = KIND_AND;
                end
                CH_BAR: begin
                    s.emit = 1'b1;
                    s.kind = KIND_OR;
                end
                CH_EQ:   s.mode = MODE_EQ;
                CH_LT:   s.mode = MODE_LT;
                default: s.mode = MODE_ERR;
            endcase
        end
        return s;
    endfunction

    always_comb begin
        if (tp_reg == TRUE_LEN) begin
            close_kind = KIND_TRUE;
        end else if (fp_reg == FALSE_LEN) begin
            close_kind = KIND_FALSE;
        end else begin
            close_kind = KIND_ID;
        end
    end

    always_comb begin
        st        = start_char(in_char);
        mode_next = mode_reg;
        tp_next   = tp_reg;
        fp_next   = fp_reg;
        so        = '0;
        if (in_eoi) begin
            mode_next = MODE_IDLE;
            tp_next   = 3'd0;
            fp_next   = 3'd0;
            so.count  = 2'd1;
            case (mode_reg)
                MODE_IDENT: begin
                    so.first.kind  = close_kind;
                    so.second.kind = KIND_END;
                    so.count       = 2'd2;
                end
                MODE_IDLE: so.first.kind = KIND_END;
                default:   so.first.kind = KIND_ERROR;
            endcase
        end else begin
            case (mode_reg)
                MODE_IDLE: begin
                    mode_next = st.mode;
                    tp_next   = st.tp;
                    fp_next   = st.fp;
                    if (st.emit) begin
                        so.first.kind = st.kind;
                        so.first.ch   = st.ch;
                        so.count      = 2'd1;
                    end
                end
                MODE_IDENT: begin
                    if (is_letter(in_char) || is_digit(in_char)) begin
                        tp_next       = adv_true(tp_reg, in_char);
                        fp_next       = adv_false(fp_reg, in_char);
                        so.first.kind = KIND_CHAR;
                        so.first.ch   = in_char;
                        so.count      = 2'd1;
                    end else begin
                        // close the identifier, then treat the character as a fresh start
                        so.first.kind = close_kind;
                        so.count      = 2'd1;
                        mode_next     = st.mode;
                        tp_next       = st.tp;
                        fp_next       = st.fp;
                        if (st.emit) begin
                            so.second.kind = st.kind;
                            so.second.ch   = st.ch;
                            so.count       = 2'd2;
                        end
                    end
                end
                MODE_EQ: begin
                    if (in_char == CH_GT) begin
                        so.first.kind = KIND_IMPLIES;
                        so.count      = 2'd1;
                        mode_next     = MODE_IDLE;
                    end else begin
                        mode_next = MODE_ERR;
                    end
                end
                MODE_LT: begin
                    mode_next = (in_char == CH_EQ) ? MODE_LTEQ : MODE_ERR;
                end
                MODE_LTEQ: begin
                    if (in_char == CH_GT) begin
                        so.first.kind = KIND_IFF;
                        so.count      = 2'd1;
                        mode_next     = MODE_IDLE;
                    end else begin
                        mode_next = MODE_ERR;
                    end
                end
                default: mode_next = MODE_ERR;
            endcase
        end
        if (so.count == 2'd1) begin
            so.first.last = 1'b1;
        end
        if (so.count == 2'd2) begin
            so.second.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            tp_reg   <= 3'd0;
            fp_reg   <= 3'd0;
        end else if (in_take) begin
            mode_reg <= mode_next;
            tp_reg   <= tp_next;
            fp_reg   <= fp_next;
        end
    end

    assign scan_out = so;

endmodule

FILE: rtl/lft_out_queue.sv
// four-entry result queue, takes up to two results per cycle, gives one when out_ready is high
module lft_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lft_pkg::scan_out_t  push_data,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output lft_pkg::result_t    out_data
);
    import lft_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    result_t          q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic [1:0]       n_push;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign n_push     = push ? push_data.count : 2'd0;
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            q_reg[wr_ptr_reg] <= push_data.first;
        end
        if (n_push == 2'd2) begin
            q_reg[wr_ptr_inc] <= push_data.second;
        end
    end

    // always keep space for a two-result request
    assign room      = cnt_reg <= (PTR_W+1)'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_data  = q_reg[rd_ptr_reg];

endmodule

FILE: rtl/lft_checker.sv
// port-level checks for the tokenizer, bound to the top level
module lft_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    import lft_pkg::*;

    logic in_seen;
    assign in_seen = s_tvalid && s_tready && (s_tdata != 8'h00 || s_tlast);

    // a held result does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // character echo, END and ERROR always close the run of their request
    a_closing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CHAR || m_tuser == KIND_END
            || m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("closing token without tlast");

    // only identifier characters carry data
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_CHAR |-> m_tdata == 8'h00)
        else $error("token carries data");

    // an identifier character is a letter or digit
    a_char_alnum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_CHAR |-> is_letter(m_tdata) || is_digit(m_tdata))
        else $error("echoed character is not alphanumeric");

    // an end mark always gives a result, so output is busy in the next cycle
    a_eoi_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_seen && s_tlast |=> m_tvalid)
        else $error("end of input gave no result");

endmodule

bind logic_formula_tokenizer_core lft_checker u_lft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/logic_formula_tokenizer_core_test.sv
// testbench for the formula tokenizer: directed probes, then random token streams
`timescale 1ns / 100ps

module logic_formula_tokenizer_core_test;
    import lft_pkg::*;

    localparam int RANDOM_ITEMS = 920;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]  c;
        logic        eoi;
        logic        typed;
        token_kind_t kind;
    } probe_t;

    // rows with typed set carry their single expected token, the rest use the predictor
    localparam int NUM_PROBES = 31;
    localparam probe_t PROBES [NUM_PROBES] = '{
        '{8'h00,    1'b1, 1'b1, KIND_END},      // end mark right after reset
        '{CH_LPAR,  1'b0, 1'b1, KIND_LPAREN},
        '{CH_RPAR,  1'b0, 1'b1, KIND_RPAREN},
        '{CH_BANG,  1'b0, 1'b1, KIND_NOT},
        '{CH_AMP,   1'b0, 1'b1, KIND_AND},
        '{CH_BAR,   1'b0, 1'b1, KIND_OR},
        '{CH_TAB,   1'b0, 1'b0, KIND_END},      // skipped
        '{CH_EQ,    1'b0, 1'b0, KIND_END},
        '{CH_GT,    1'b0, 1'b1, KIND_IMPLIES},
        '{CH_LT,    1'b0, 1'b0, KIND_END},
        '{CH_EQ,    1'b0, 1'b0, KIND_END},
        '{CH_GT,    1'b0, 1'b1, KIND_IFF},
        '{"T",      1'b0, 1'b0, KIND_END},
        '{"r",      1'b0, 1'b0, KIND_END},
        '{"u",      1'b0, 1'b0, KIND_END},
        '{"e",      1'b0, 1'b0, KIND_END},
        '{CH_LF,    1'b0, 1'b0, KIND_END},      // closes the keyword
        '{"F",      1'b0, 1'b0, KIND_END},
        '{"a",      1'b0, 1'b0, KIND_END},
        '{"l",      1'b0, 1'b0, KIND_END},
        '{"s",      1'b0, 1'b0, KIND_END},
        '{"e",      1'b0, 1'b0, KIND_END},
        '{8'hFF,    1'b1, 1'b0, KIND_END},      // end inside identifier, data ignored
        '{8'hFF,    1'b0, 1'b0, KIND_END},      // non-ascii start
        '{"A",      1'b0, 1'b0, KIND_END},      // absorbed
        '{8'h00,    1'b1, 1'b1, KIND_ERROR},
        '{CH_LT,    1'b0, 1'b0, KIND_END},
        '{8'h00,    1'b1, 1'b1, KIND_ERROR},    // end inside a symbol
        '{CH_EQ,    1'b0, 1'b0, KIND_END},
        '{"x",      1'b0, 1'b0, KIND_END},      // broken symbol
        '{8'h00,    1'b1, 1'b1, KIND_ERROR}
    };

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    logic_formula_tokenizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // lexer state as predicted
    scan_mode_t lex_mode   = MODE_IDLE;
    logic [2:0] true_seen  = 3'd0;
    logic [2:0] false_seen = 3'd0;

    result_t step_tokens[$];
    result_t pending_tokens[$];

    int  error_count = 0;
    int  live_items  = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_TAB;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        logic [7:0] up;
        up = c & 8'hDF;
        return up >= "A" && up <= "Z";
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [2:0] match_next(input logic [2:0] seen, input string word,
                                              input logic [7:0] c);
        if (seen < word.len() && word[seen] == c)
            return seen + 3'd1;
        return NO_MATCH;
    endfunction

    function automatic void put_token(input token_kind_t k, input logic [7:0] ch);
        result_t r;
        r.kind = k;
        r.ch   = ch;
        r.last = 1'b0;
        step_tokens = {step_tokens, r};
    endfunction

    function automatic void clear_lexer();
        lex_mode   = MODE_IDLE;
        true_seen  = 3'd0;
        false_seen = 3'd0;
    endfunction

    function automatic void close_word();
        if (true_seen == 3'd4)
            put_token(KIND_TRUE, 8'h00);
        else if (false_seen == 3'd5)
            put_token(KIND_FALSE, 8'h00);
        else
            put_token(KIND_ID, 8'h00);
        clear_lexer();
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (is_blank(c))
            return;
        if (is_alpha(c)) begin
            lex_mode   = MODE_IDENT;
            true_seen  = match_next(3'd0, "True", c);
            false_seen = match_next(3'd0, "False", c);
            put_token(KIND_CHAR, c);
            return;
        end
        case (c)
            CH_LPAR: put_token(KIND_LPAREN, 8'h00);
            CH_RPAR: put_token(KIND_RPAREN, 8'h00);
            CH_BANG: put_token(KIND_NOT, 8'h00);
            CH_AMP:  put_token(KIND_AND, 8'h00);
            CH_BAR:  put_token(KIND_OR, 8'h00);
            CH_EQ:   lex_mode = MODE_EQ;
            CH_LT:   lex_mode = MODE_LT;
            default: lex_mode = MODE_ERR;
        endcase
    endfunction

    // tokens caused by one request, left in step_tokens
    function automatic void lex_step(input logic [7:0] c, input logic eoi);
        step_tokens.delete();
        if (eoi) begin
            if (lex_mode == MODE_IDENT) begin
                close_word();
                put_token(KIND_END, 8'h00);
            end else if (lex_mode == MODE_IDLE) begin
                put_token(KIND_END, 8'h00);
            end else begin
                put_token(KIND_ERROR, 8'h00);
            end
            clear_lexer();
        end else begin
            case (lex_mode)
                MODE_IDLE: open_token(c);
                MODE_IDENT: begin
                    if (is_alpha(c) || is_num(c)) begin
                        true_seen  = match_next(true_seen, "True", c);
                        false_seen = match_next(false_seen, "False", c);
                        put_token(KIND_CHAR, c);
                    end else begin
                        close_word();
                        open_token(c);
                    end
                end
                MODE_EQ: begin
                    if (c == CH_GT) begin
                        put_token(KIND_IMPLIES, 8'h00);
                        lex_mode = MODE_IDLE;
                    end else begin
                        lex_mode = MODE_ERR;
                    end
                end
                MODE_LT:   lex_mode = (c == CH_EQ) ? MODE_LTEQ : MODE_ERR;
                MODE_LTEQ: begin
                    if (c == CH_GT) begin
                        put_token(KIND_IFF, 8'h00);
                        lex_mode = MODE_IDLE;
                    end else begin
                        lex_mode = MODE_ERR;
                    end
                end
                default: ;
            endcase
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 90)
            return $urandom_range(3, 6);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoi,
                             input logic typed = 1'b0, input token_kind_t typed_kind = KIND_END);
        int gap;
        result_t r;
        if ($urandom_range(0, 149) == 0)
            tx_calm = !tx_calm;
        gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do @(posedge aclk); while (!s_tready);
        live_items++;
        lex_step(c, eoi);
        if (typed) begin
            r.kind = typed_kind;
            r.ch   = 8'h00;
            r.last = 1'b1;
            pending_tokens = {pending_tokens, r};
        end else begin
            foreach (step_tokens[i])
                pending_tokens = {pending_tokens, step_tokens[i]};
        end
    endtask

    task automatic send_word(input string w);
        for (int i = 0; i < w.len(); i++)
            send_char(w[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? "0" + 8'($urandom_range(0, 9)) : rand_letter();
    endfunction

    // mostly well formed tokens, with a share of end marks, stray bytes and broken symbols
    task automatic random_phrase();
        int pick;
        string w;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_char(rand_letter(), 1'b0);
            repeat ($urandom_range(0, 6)) send_char(rand_alnum(), 1'b0);
        end else if (pick < 38) begin
            case ($urandom_range(0, 5))
                0: w = "True";
                1: w = "False";
                2: w = "Tru";
                3: w = "Falsey";
                4: w = "true";
                default: w = "FalseTrue";
            endcase
            send_word(w);
        end else if (pick < 55) begin
            case ($urandom_range(0, 4))
                0: c = CH_LPAR;
                1: c = CH_RPAR;
                2: c = CH_BANG;
                3: c = CH_AMP;
                default: c = CH_BAR;
            endcase
            send_char(c, 1'b0);
        end else if (pick < 62) begin
            send_word("=>");
        end else if (pick < 68) begin
            send_word("<=>");
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: c = CH_SPACE;
                    1: c = CH_LF;
                    default: c = CH_TAB;
                endcase
                send_char(c, 1'b0);
            end
        end else if (pick < 89) begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 94) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            case ($urandom_range(0, 2))
                0: send_word("=");
                1: send_word("<");
                default: send_word("<=");
            endcase
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // result side: random stalls, with calm stretches of none
    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0)
            rx_calm <= !rx_calm;
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_calm || $urandom_range(0, 99) >= 25) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold  <= idle_len() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected token: kind %0d char %02h last %0b",
                             m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (m_tuser !== want.kind || m_tdata !== want.ch || m_tlast !== want.last) begin
                    if (error_count < MAX_REPORTS)
                        $display("token mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                 want.kind, want.ch, want.last, m_tuser, m_tdata, m_tlast);
                    error_count++;
                end
            end
        end
        // watchdog on traffic in either direction
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < NUM_PROBES; i++)
            send_char(PROBES[i].c, PROBES[i].eoi, PROBES[i].typed, PROBES[i].kind);
        while (live_items < NUM_PROBES + RANDOM_ITEMS)
            random_phrase();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
